@@ rtl/sspcrc_pkg.sv @@
// Shared constants, types and the CRC-8 update function for the scratchpad checker.
package sspcrc_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int BYTE_W      = 8;
   localparam int NIBBLE_W    = 4;
   localparam int TEMP_W      = 12;
   localparam int RSP_DATA_W  = 16;

   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0]  IDX_FIRST  = '0;
   localparam logic [IDX_W-1:0]  IDX_SECOND = IDX_W'(1);
   localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h8C;
   localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;

   typedef struct packed {
      logic              has_result;
      logic [TEMP_W-1:0] temp;
      logic              crc_ok;
   } sspcrc_result_type;

   // Reflected Maxim CRC-8, one byte at a time (eight narrow shift/xor steps).
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/sspcrc_frame.sv @@
// Frame tracker: byte position, running CRC, held temperature bytes and last good reading.
module sspcrc_frame
   import sspcrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [BYTE_W-1:0] scratch_byte,
   input  logic              frame_start,
   output sspcrc_result_type result
);

   logic [IDX_W-1:0]    byte_index_ff, byte_index_in;
   logic [BYTE_W-1:0]   running_crc_ff, running_crc_in;
   logic [BYTE_W-1:0]   low_byte_ff, low_byte_in;
   logic [NIBBLE_W-1:0] high_nibble_ff, high_nibble_in;
   logic [TEMP_W-1:0]   last_good_ff, last_good_in;

   logic [IDX_W-1:0]  cur_idx;
   logic [BYTE_W-1:0] cur_crc;
   logic [TEMP_W-1:0] fresh_temp;
   logic              is_last;
   logic              crc_match;

   always_comb begin
      // A frame start drops any partial frame and treats this byte as byte0.
      cur_idx    = frame_start ? IDX_FIRST : byte_index_ff;
      cur_crc    = frame_start ? CRC_INIT : running_crc_ff;
      is_last    = (cur_idx == LAST_IDX);
      crc_match  = (cur_crc == scratch_byte);
      fresh_temp = {high_nibble_ff, low_byte_ff};

      byte_index_in  = byte_index_ff;
      running_crc_in = running_crc_ff;
      low_byte_in    = low_byte_ff;
      high_nibble_in = high_nibble_ff;
      last_good_in   = last_good_ff;

      if (step_en) begin
         if (is_last) begin
            byte_index_in  = IDX_FIRST;
            running_crc_in = CRC_INIT;
            if (crc_match) begin
               last_good_in = fresh_temp;
            end
         end else begin
            if (cur_idx == IDX_FIRST) begin
               low_byte_in = scratch_byte;
            end else if (cur_idx == IDX_SECOND) begin
               high_nibble_in = scratch_byte[NIBBLE_W-1:0];
            end
            running_crc_in = crc8_update(cur_crc, scratch_byte);
            byte_index_in  = cur_idx + IDX_W'(1);
         end
      end

      result.has_result = is_last;
      result.crc_ok     = crc_match;
      result.temp       = crc_match ? fresh_temp : last_good_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= '0;
         running_crc_ff <= '0;
         low_byte_ff    <= '0;
         high_nibble_ff <= '0;
         last_good_ff   <= '0;
      end else begin
         byte_index_ff  <= byte_index_in;
         running_crc_ff <= running_crc_in;
         low_byte_ff    <= low_byte_in;
         high_nibble_ff <= high_nibble_in;
         last_good_ff   <= last_good_in;
      end
   end

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= LAST_IDX)
      else $error("byte position ran past the end of the frame");

   a_good_frame_stored: assert property (@(posedge clock) disable iff (reset)
      step_en && result.has_result && result.crc_ok |=> last_good_ff == $past(fresh_temp))
      else $error("good frame did not update the last good reading");

   a_frame_restarts: assert property (@(posedge clock) disable iff (reset)
      step_en && result.has_result |=> byte_index_ff == IDX_FIRST && running_crc_ff == CRC_INIT)
      else $error("frame state not cleared after the check byte");

endmodule

@@ rtl/sensor_scratchpad_crc_checker_top.sv @@
// Top level of the sensor scratchpad CRC checker: input register, frame tracker, result register.
//
// Requests arrive on the req_ stream, one scratchpad byte per request in bus order, with
// req_tuser high on the first byte of a frame. A frame holds FRAME_BYTES bytes: the CRC-8
// (reflected polynomial 0x8C, start value zero) runs over all but the last, and the last is
// the check byte. Only the check byte produces a result on the rsp_ stream: rsp_tdata holds
// the 12-bit temperature in sixteenths of a degree and rsp_tuser is high when the CRC matched.
// On a mismatch the last reading that passed its CRC is reported instead (zero until then).
// A request is registered in the input register at the edge where it is accepted; the frame
// tracker processes it from that register, and a check byte's result is written into the output
// register, which drives rsp_tvalid. One request is taken in every cycle while the output flows.
// When the receiver stalls, the result waits in the output register while one more request
// waits in the input register; bytes that produce no result keep flowing past a stalled
// result, and only a check byte arriving behind a waiting result holds the input side.
// A synchronous reset empties both registers, clears the frame position and running CRC, and
// sets the last good reading to zero. A frame start in mid-frame drops the partial frame, and
// bytes that follow a complete frame without a frame start begin a new frame on their own.
module sensor_scratchpad_crc_checker_top
   import sspcrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] scratch_byte
   input  logic                  req_tuser,   // [0] frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] temp_sixteenths, [15:12] zero
   output logic                  rsp_tuser    // [0] crc_ok
);

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [TEMP_W-1:0] out_temp_ff;
   logic              out_ok_ff;

   sspcrc_result_type result;
   logic              out_free;
   logic              step_en;
   logic              req_fire;

   sspcrc_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .scratch_byte (in_byte_ff),
      .frame_start  (in_start_ff),
      .result       (result)
   );

   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      // A byte with no result never needs the output register.
      step_en    = in_valid_ff && (!result.has_result || out_free);
      req_tready = !in_valid_ff || step_en;
      req_fire   = req_tvalid && req_tready;

      in_valid_in = req_fire || (in_valid_ff && !step_en);

      if (step_en && result.has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (step_en && result.has_result) begin
         out_temp_ff <= result.temp;
         out_ok_ff   <= result.crc_ok;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - TEMP_W){1'b0}}, out_temp_ff};
   assign rsp_tuser  = out_ok_ff;

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !out_valid_ff && !in_valid_ff)
      else $error("registers not empty after reset");

   a_held_request_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_en |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_start_ff))
      else $error("waiting request lost or changed");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      step_en && result.has_result |-> !out_valid_ff || rsp_tready)
      else $error("result written over one not yet taken");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && result.has_result)
      else $error("input stalled without cause");

endmodule
